// ===== rtl/tknl_pkg.sv =====
// shared constants and controller-to-datapath command type for the top-k list
package tknl_pkg;

    // fixed payload and opcode widths
    localparam int ID_W   = 32;
    localparam int DIST_W = 16;
    localparam int OP_W   = 2;

    // default list depth
    localparam int LIST_SIZE_DEF = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the candidate of an accepted transaction
        logic clear;       // empty every slot
        logic compare;     // register per-slot compare results
        logic update;      // apply the insertion and shift
        logic load_tail;   // report the last slot
        logic drain_step;  // report slot 0 and rotate the list by one
        logic last;        // final result of this transaction
    } t_dp_cmd;

endpackage

// ===== rtl/tknl_dp.sv =====
// slot registers, per-slot compare and shift network, result register
module tknl_dp #(
    parameter int LIST_SIZE = tknl_pkg::LIST_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tknl_pkg::t_dp_cmd         i_cmd,
    input  logic [tknl_pkg::ID_W-1:0]   i_candidate_id,
    input  logic [tknl_pkg::DIST_W-1:0] i_candidate_distance,
    output logic                      o_strobe,
    output logic [tknl_pkg::ID_W-1:0]   o_entry_id,
    output logic [tknl_pkg::DIST_W-1:0] o_entry_distance,
    output logic                      o_entry_valid,
    output logic                      o_inserted,
    output logic                      o_last
);
    import tknl_pkg::*;

    // slot storage, one cell per slot
    logic [ID_W-1:0]      r_ids  [LIST_SIZE];
    logic [DIST_W-1:0]    r_dist [LIST_SIZE];
    logic [LIST_SIZE-1:0] r_vld;
    logic [ID_W-1:0]      n_ids  [LIST_SIZE];
    logic [DIST_W-1:0]    n_dist [LIST_SIZE];
    logic [LIST_SIZE-1:0] n_vld;

    // latched candidate
    logic [ID_W-1:0]   r_cand_id;
    logic [DIST_W-1:0] r_cand_dist;

    // registered compare results
    logic [LIST_SIZE-1:0] r_cond;   // slot empty or farther than candidate
    logic [LIST_SIZE-1:0] r_hit;    // slot valid and holds the same id
    logic [LIST_SIZE-1:0] n_cond;
    logic [LIST_SIZE-1:0] n_hit;
    logic [LIST_SIZE-1:0] w_prev;   // condition of the slot before
    logic                 w_reject;
    logic                 r_ins;

    // result register
    logic              r_strobe;
    logic [ID_W-1:0]   r_out_id;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_vld;
    logic              r_out_ins;
    logic              r_out_last;

    // per-slot compares, independent for each slot
    always_comb begin
        for (int j = 0; j < LIST_SIZE; j++) begin
            n_cond[j] = !r_vld[j] || (r_cand_dist < r_dist[j]);
            n_hit[j]  = r_vld[j] && (r_ids[j] == r_cand_id);
        end
    end

    // a match counts only at or before the insert point
    always_comb begin
        for (int j = 0; j < LIST_SIZE; j++) begin
            if (j == 0) begin
                w_prev[j] = 1'b0;
            end else begin
                w_prev[j] = r_cond[j-1];
            end
        end
        w_reject = |(r_hit & ~w_prev);
    end

    // next slot contents: clear, insert and shift, or rotate for drain
    always_comb begin
        for (int j = 0; j < LIST_SIZE; j++) begin
            n_ids[j]  = r_ids[j];
            n_dist[j] = r_dist[j];
            n_vld[j]  = r_vld[j];
            if (i_cmd.clear) begin
                n_ids[j]  = '0;
                n_dist[j] = '0;
                n_vld[j]  = 1'b0;
            end else if (i_cmd.update && !w_reject) begin
                if (w_prev[j]) begin
                    n_ids[j]  = r_ids[(j == 0) ? 0 : j-1];
                    n_dist[j] = r_dist[(j == 0) ? 0 : j-1];
                    n_vld[j]  = r_vld[(j == 0) ? 0 : j-1];
                end else if (r_cond[j]) begin
                    n_ids[j]  = r_cand_id;
                    n_dist[j] = r_cand_dist;
                    n_vld[j]  = 1'b1;
                end
            end else if (i_cmd.drain_step) begin
                n_ids[j]  = r_ids[(j == LIST_SIZE-1) ? 0 : j+1];
                n_dist[j] = r_dist[(j == LIST_SIZE-1) ? 0 : j+1];
                n_vld[j]  = r_vld[(j == LIST_SIZE-1) ? 0 : j+1];
            end
        end
    end

    // slot payload registers
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LIST_SIZE; j++) begin
            r_ids[j]  <= n_ids[j];
            r_dist[j] <= n_dist[j];
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // candidate, compare and insert flag registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cand_id   <= i_candidate_id;
            r_cand_dist <= i_candidate_distance;
        end
        if (i_cmd.compare) begin
            r_cond <= n_cond;
            r_hit  <= n_hit;
        end
        if (i_cmd.capture) begin
            r_ins <= 1'b0;
        end else if (i_cmd.update) begin
            r_ins <= r_cond[LIST_SIZE-1] && !w_reject;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load_tail || i_cmd.drain_step;
        end
    end

    // result payload, empty slots report zeros
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tail) begin
            r_out_id   <= r_vld[LIST_SIZE-1] ? r_ids[LIST_SIZE-1] : '0;
            r_out_dist <= r_vld[LIST_SIZE-1] ? r_dist[LIST_SIZE-1] : '0;
            r_out_vld  <= r_vld[LIST_SIZE-1];
            r_out_ins  <= r_ins;
            r_out_last <= i_cmd.last;
        end else if (i_cmd.drain_step) begin
            r_out_id   <= r_vld[0] ? r_ids[0] : '0;
            r_out_dist <= r_vld[0] ? r_dist[0] : '0;
            r_out_vld  <= r_vld[0];
            r_out_ins  <= 1'b0;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_entry_id       = r_out_id;
    assign o_entry_distance = r_out_dist;
    assign o_entry_valid    = r_out_vld;
    assign o_inserted       = r_out_ins;
    assign o_last           = r_out_last;

endmodule

// ===== rtl/tknl_ctrl.sv =====
// controller state machine sequencing clear, offer and drain transactions
module tknl_ctrl #(
    parameter int LIST_SIZE = tknl_pkg::LIST_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tknl_pkg::OP_W-1:0]   i_operation,
    output tknl_pkg::t_dp_cmd           o_cmd
);
    import tknl_pkg::*;

    localparam int CNT_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIST_SIZE - 1);

    // state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_INS    = 3'd2;
    localparam logic [2:0] S_REPORT = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // next state and drain counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_operation)
                        OP_CLEAR: n_state = S_REPORT;
                        OP_OFFER: n_state = S_CMP;
                        OP_DRAIN: begin
                            n_state = S_DRAIN;
                            n_cnt   = '0;
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CMP:    n_state = S_INS;
            S_INS:    n_state = S_REPORT;
            S_REPORT: n_state = S_IDLE;
            S_DRAIN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd.capture    = w_accept;
        o_cmd.clear      = w_accept && (i_operation == OP_CLEAR);
        o_cmd.compare    = (r_state == S_CMP);
        o_cmd.update     = (r_state == S_INS);
        o_cmd.load_tail  = (r_state == S_REPORT);
        o_cmd.drain_step = (r_state == S_DRAIN);
        o_cmd.last       = (r_state == S_REPORT) ||
                           ((r_state == S_DRAIN) && (r_cnt == CNT_LAST));
    end

endmodule

// ===== rtl/top_k_nearest_list_core.sv =====
// top level of the sorted top-k nearest candidate list
// A transaction is taken when start is high and busy is low. Clear returns
// one result, loaded from the tail slot in the report state. An offer
// registers the candidate, registers its compares across all slots, applies
// the insert and shift and loads the tail slot, returning one result. A
// drain returns LIST_SIZE results on consecutive cycles, slot 0 each time,
// while the list rotates through slot 0 and comes back to its original
// order. Busy stays high until these steps are through, so the next
// transaction waits for it to fall. Each result is shown for one cycle with
// o_strobe high and cannot be held off, so the receiver must take it then.
// Operation code 3 is accepted and ignored, with no result.
module top_k_nearest_list_core #(
    parameter int LIST_SIZE = tknl_pkg::LIST_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tknl_pkg::OP_W-1:0]     i_operation,
    input  logic [tknl_pkg::ID_W-1:0]     i_candidate_id,
    input  logic [tknl_pkg::DIST_W-1:0]   i_candidate_distance,
    output logic                          o_strobe,
    output logic [tknl_pkg::ID_W-1:0]     o_entry_id,
    output logic [tknl_pkg::DIST_W-1:0]   o_entry_distance,
    output logic                          o_entry_valid,
    output logic                          o_inserted,
    output logic                          o_last
);
    import tknl_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer
    tknl_ctrl #(
        .LIST_SIZE (LIST_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .o_cmd       (w_cmd)
    );

    // slot storage and result register
    tknl_dp #(
        .LIST_SIZE (LIST_SIZE)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_candidate_id       (i_candidate_id),
        .i_candidate_distance (i_candidate_distance),
        .o_strobe             (o_strobe),
        .o_entry_id           (o_entry_id),
        .o_entry_distance     (o_entry_distance),
        .o_entry_valid        (o_entry_valid),
        .o_inserted           (o_inserted),
        .o_last               (o_last)
    );

endmodule
